// ----- rtl/ats_pkg.sv -----
package ats_pkg;

	localparam int VALUE_BITS_DEF  = 32;
	localparam int IDENT_LIMIT_DEF = 100;
	localparam int MAX_TOKENS      = 3;

	// character classes; codes below 16 are the digit value
	localparam logic [4:0] CL_ID  = 5'd16;
	localparam logic [4:0] CL_SP  = 5'd17;
	localparam logic [4:0] CL_BAD = 5'd18;
	localparam logic [4:0] CL_EOL = 5'd19;
	localparam logic [4:0] CL_OP  = 5'd20;
	localparam logic [4:0] CL_QT  = 5'd21;

	localparam logic [4:0] BASE_DEC_VAL = 5'd10;
	localparam logic [4:0] BASE_OCT_VAL = 5'd8;
	localparam logic [4:0] BASE_HEX_VAL = 5'd16;

	// token kinds
	localparam logic [2:0] K_OP    = 3'd0;
	localparam logic [2:0] K_EOL   = 3'd1;
	localparam logic [2:0] K_NUM   = 3'd2;
	localparam logic [2:0] K_LREF  = 3'd3;
	localparam logic [2:0] K_IDCH  = 3'd4;
	localparam logic [2:0] K_IDEND = 3'd5;
	localparam logic [2:0] K_EOF   = 3'd6;
	localparam logic [2:0] K_ERR   = 3'd7;

	// error codes
	localparam logic [2:0] E_BAD_CHAR  = 3'd0;
	localparam logic [2:0] E_OPEN_COM  = 3'd1;
	localparam logic [2:0] E_BAD_CTRL  = 3'd2;
	localparam logic [2:0] E_BAD_ESC   = 3'd3;
	localparam logic [2:0] E_ID_LONG   = 3'd4;

	typedef enum logic [3:0] {
		M_IDLE  = 4'd0,
		M_IDENT = 4'd1,
		M_ZERO  = 4'd2,
		M_NUM   = 4'd3,
		M_SLASH = 4'd4,
		M_LCOM  = 4'd5,
		M_BCOM  = 4'd6,
		M_BSTAR = 4'd7,
		M_QUOTE = 4'd8,
		M_ESC   = 4'd9,
		M_CTRL  = 4'd10,
		M_HALT  = 4'd11
	} mode_t;

	typedef enum logic [1:0] {
		NB_DEC = 2'd0,
		NB_OCT = 2'd1,
		NB_HEX = 2'd2
	} base_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [31:0] value;
		logic [2:0]  code;
	} tok_t;

	typedef struct packed {
		logic [1:0]  count;
		tok_t [2:0]  tok;
	} tok_set_t;

	function automatic tok_t mk_tok(logic [2:0] kind, logic [7:0] ch, logic [31:0] value,
			logic [2:0] code);
		tok_t t;
		t.kind  = kind;
		t.ch    = ch;
		t.value = value;
		t.code  = code;
		return t;
	endfunction

	function automatic logic [4:0] class_of(logic [7:0] ch);
		logic [4:0] c;
		c = CL_BAD;
		if (ch == 8'h09 || ch == 8'h20)
			c = CL_SP;
		else if (ch == 8'h0A || ch == ";")
			c = CL_EOL;
		else if (ch >= "0" && ch <= "9")
			c = 5'(ch - "0");
		else if (ch >= "A" && ch <= "F")
			c = 5'(ch - "A" + 8'd10);
		else if (ch >= "a" && ch <= "f")
			c = 5'(ch - "a" + 8'd10);
		else if ((ch >= "G" && ch <= "Z") || (ch >= "g" && ch <= "z") ||
				ch == "." || ch == "_" || ch == "~")
			c = CL_ID;
		else if (ch == "'")
			c = CL_QT;
		else if (ch == "!" || ch == "%" || ch == "&" || (ch >= "(" && ch <= "-") ||
				ch == "/" || ch == ":" || (ch >= "<" && ch <= "?") ||
				ch == "[" || ch == "]" || ch == "|")
			c = CL_OP;
		return c;
	endfunction

endpackage

// ----- rtl/ats_scan.sv -----
module ats_scan #(
	parameter int VALUE_BITS  = ats_pkg::VALUE_BITS_DEF,
	parameter int IDENT_LIMIT = ats_pkg::IDENT_LIMIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        ch,
	input  logic              is_end,
	output ats_pkg::tok_set_t set
);

	ats_pkg::mode_t          mode_q, nm;
	ats_pkg::base_t          base_q, nbase;
	logic [VALUE_BITS-1:0]   acc_q, nacc;
	logic [6:0]              len_q, nlen;

	logic [4:0]              cls;
	logic [4:0]              cnum;
	logic [4:0]              bval;
	logic                    again;
	logic                    do_num;
	logic                    do_ident;
	logic                    esc_bad;
	logic [7:0]              esc_v;
	logic [1:0]              n;
	ats_pkg::tok_t [2:0]     t;
	logic signed [8:0]       diff;
	logic [VALUE_BITS-1:0]   ctrl_v;
	logic [VALUE_BITS-1:0]   acc_x10;
	logic [VALUE_BITS-1:0]   acc_x8;
	logic [VALUE_BITS-1:0]   acc_x16;

	assign cls     = ats_pkg::class_of(ch);
	assign diff    = $signed({1'b0, ch}) - 9'sd64;
	assign ctrl_v  = VALUE_BITS'(diff);

	always_comb begin
		nm       = mode_q;
		nacc     = acc_q;
		nbase    = base_q;
		nlen     = len_q;
		n        = 2'd0;
		t        = '0;
		again    = 1'b0;
		do_num   = 1'b0;
		do_ident = 1'b0;
		esc_bad  = 1'b0;
		esc_v    = 8'd0;
		cnum     = ats_pkg::CL_BAD;
		bval     = ats_pkg::BASE_DEC_VAL;
		acc_x10  = '0;
		acc_x8   = '0;
		acc_x16  = '0;

		case (mode_q)
			ats_pkg::M_IDLE: begin
				again = 1'b1;
			end
			ats_pkg::M_IDENT: begin
				if (!is_end && cls <= ats_pkg::CL_ID) begin
					do_ident = 1'b1;
				end else begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_IDEND, 8'd0, 32'd0, 3'd0);
					n = n + 2'd1;
					nlen  = 7'd0;
					nm    = ats_pkg::M_IDLE;
					again = 1'b1;
				end
			end
			ats_pkg::M_ZERO: begin
				nm = ats_pkg::M_NUM;
				if (!is_end && (ch == "x" || ch == "X")) begin
					nbase = ats_pkg::NB_HEX;
				end else begin
					nbase  = ats_pkg::NB_OCT;
					do_num = 1'b1;
				end
			end
			ats_pkg::M_NUM: begin
				do_num = 1'b1;
			end
			ats_pkg::M_SLASH: begin
				if (!is_end && ch == "/") begin
					nm = ats_pkg::M_LCOM;
				end else if (!is_end && ch == "*") begin
					nm = ats_pkg::M_BCOM;
				end else begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_OP, "/", 32'd0, 3'd0);
					n = n + 2'd1;
					nm    = ats_pkg::M_IDLE;
					again = 1'b1;
				end
			end
			ats_pkg::M_LCOM: begin
				if (is_end || ch == 8'h0A) begin
					nm    = ats_pkg::M_IDLE;
					again = 1'b1;
				end
			end
			ats_pkg::M_BCOM, ats_pkg::M_BSTAR: begin
				if (is_end) begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_ERR, 8'd0, 32'd0, ats_pkg::E_OPEN_COM);
					n = n + 2'd1;
					nm    = ats_pkg::M_IDLE;
					again = 1'b1;
				end else if (ch == "*") begin
					nm = ats_pkg::M_BSTAR;
				end else if (ch == "/" && mode_q == ats_pkg::M_BSTAR) begin
					nm = ats_pkg::M_IDLE;
				end else begin
					nm = ats_pkg::M_BCOM;
				end
			end
			ats_pkg::M_QUOTE: begin
				nm = ats_pkg::M_IDLE;
				if (is_end) begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_NUM, 8'd0, 32'd0, 3'd0);
					n = n + 2'd1;
					again = 1'b1;
				end else if (ch == "\\") begin
					nm = ats_pkg::M_ESC;
				end else begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_NUM, 8'd0, 32'(ch), 3'd0);
					n = n + 2'd1;
				end
			end
			ats_pkg::M_ESC: begin
				nm = ats_pkg::M_IDLE;
				if (is_end) begin
					esc_bad = 1'b1;
				end else begin
					case (ch)
						"n":     esc_v = 8'd10;
						"r":     esc_v = 8'd13;
						"b":     esc_v = 8'd8;
						"e":     esc_v = 8'd27;
						"s":     esc_v = 8'd32;
						"t":     esc_v = 8'd9;
						"0":     esc_v = 8'd0;
						">":     esc_v = 8'd62;
						"\\":    esc_v = 8'd92;
						"^":     nm = ats_pkg::M_CTRL;
						default: esc_bad = 1'b1;
					endcase
				end
				if (esc_bad) begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_ERR, 8'd0, 32'd0, ats_pkg::E_BAD_ESC);
					n = n + 2'd1;
					t[n] = ats_pkg::mk_tok(ats_pkg::K_NUM, 8'd0, 32'd92, 3'd0);
					n = n + 2'd1;
					again = 1'b1;
				end else if (nm != ats_pkg::M_CTRL) begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_NUM, 8'd0, 32'(esc_v), 3'd0);
					n = n + 2'd1;
				end
			end
			ats_pkg::M_CTRL: begin
				nm = ats_pkg::M_IDLE;
				if (is_end) begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_ERR, 8'd0, 32'd0, ats_pkg::E_BAD_CTRL);
					n = n + 2'd1;
					t[n] = ats_pkg::mk_tok(ats_pkg::K_NUM, 8'd0, 32'd0, 3'd0);
					n = n + 2'd1;
					again = 1'b1;
				end else begin
					if (ch < "@" || ch > "_") begin
						t[n] = ats_pkg::mk_tok(ats_pkg::K_ERR, 8'd0, 32'd0,
							ats_pkg::E_BAD_CTRL);
						n = n + 2'd1;
					end
					t[n] = ats_pkg::mk_tok(ats_pkg::K_NUM, 8'd0, 32'(ctrl_v), 3'd0);
					n = n + 2'd1;
				end
			end
			default: begin
				nm = ats_pkg::M_HALT;
			end
		endcase

		// digit accumulate: one constant-base multiply-add
		if (do_num) begin
			cnum = is_end ? ats_pkg::CL_BAD : cls;
			case (nbase)
				ats_pkg::NB_OCT: bval = ats_pkg::BASE_OCT_VAL;
				ats_pkg::NB_HEX: bval = ats_pkg::BASE_HEX_VAL;
				default:         bval = ats_pkg::BASE_DEC_VAL;
			endcase
			acc_x10 = (acc_q << 3) + (acc_q << 1);
			acc_x8  = acc_q << 3;
			acc_x16 = acc_q << 4;
			if (cnum < bval) begin
				case (nbase)
					ats_pkg::NB_OCT: nacc = acc_x8 + VALUE_BITS'(cnum[3:0]);
					ats_pkg::NB_HEX: nacc = acc_x16 + VALUE_BITS'(cnum[3:0]);
					default:         nacc = acc_x10 + VALUE_BITS'(cnum[3:0]);
				endcase
			end else begin
				nm = ats_pkg::M_IDLE;
				if (!is_end && (ch == "b" || ch == "f")) begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_LREF, ch, 32'(acc_q), 3'd0);
					n = n + 2'd1;
				end else begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_NUM, 8'd0, 32'(acc_q), 3'd0);
					n = n + 2'd1;
					again = 1'b1;
				end
			end
		end

		// rescan from idle
		if (again && nm == ats_pkg::M_IDLE) begin
			if (is_end) begin
				t[n] = ats_pkg::mk_tok(ats_pkg::K_EOF, 8'd0, 32'd0, 3'd0);
				n = n + 2'd1;
			end else if (cls == ats_pkg::CL_BAD) begin
				t[n] = ats_pkg::mk_tok(ats_pkg::K_ERR, ch, 32'd0, ats_pkg::E_BAD_CHAR);
				n = n + 2'd1;
			end else if (cls == ats_pkg::CL_EOL) begin
				t[n] = ats_pkg::mk_tok(ats_pkg::K_EOL, 8'd0, 32'd0, 3'd0);
				n = n + 2'd1;
			end else if (cls == ats_pkg::CL_OP) begin
				if (ch == "/") begin
					nm = ats_pkg::M_SLASH;
				end else begin
					t[n] = ats_pkg::mk_tok(ats_pkg::K_OP, ch, 32'd0, 3'd0);
					n = n + 2'd1;
				end
			end else if (cls == ats_pkg::CL_QT) begin
				nm = ats_pkg::M_QUOTE;
			end else if (cls < 5'd10) begin
				nacc  = VALUE_BITS'(cls[3:0]);
				nbase = (cls == 5'd0) ? ats_pkg::NB_OCT : ats_pkg::NB_DEC;
				nm    = (cls == 5'd0) ? ats_pkg::M_ZERO : ats_pkg::M_NUM;
			end else if (cls != ats_pkg::CL_SP) begin
				nm       = ats_pkg::M_IDENT;
				nlen     = 7'd0;
				do_ident = 1'b1;
			end
		end

		// identifier character, with the length limit
		if (do_ident) begin
			t[n] = ats_pkg::mk_tok(ats_pkg::K_IDCH, ch, 32'd0, 3'd0);
			n = n + 2'd1;
			nlen = nlen + 7'd1;
			if (nlen >= 7'(IDENT_LIMIT)) begin
				t[n] = ats_pkg::mk_tok(ats_pkg::K_ERR, 8'd0, 32'd0, ats_pkg::E_ID_LONG);
				n = n + 2'd1;
				nm = ats_pkg::M_HALT;
			end
		end

		set.count = n;
		set.tok   = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ats_pkg::M_IDLE;
			base_q <= ats_pkg::NB_DEC;
			acc_q  <= '0;
			len_q  <= 7'd0;
		end else if (adv) begin
			mode_q <= nm;
			base_q <= nbase;
			acc_q  <= nacc;
			len_q  <= nlen;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ats_pkg::M_HALT |=> mode_q == ats_pkg::M_HALT)
		else $error("scanner left the halted mode");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ats_pkg::M_HALT |-> set.count == 2'd0)
		else $error("halted scanner produced tokens");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ats_pkg::M_IDENT |-> len_q < 7'(IDENT_LIMIT))
		else $error("identifier length past limit while scanning");

endmodule

// ----- rtl/ats_result_buf.sv -----
module ats_result_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ats_pkg::tok_set_t set,
	output logic              free,
	output logic              tok_valid,
	input  logic              tok_stall,
	output ats_pkg::tok_t     tok,
	output logic              last
);

	ats_pkg::tok_t [2:0] toks_q;
	logic [1:0]          n_q;
	logic [1:0]          idx_q;
	logic                take;

	assign tok_valid = (idx_q != n_q);
	assign last      = (idx_q == n_q - 2'd1);
	assign take      = tok_valid && !tok_stall;
	assign free      = !tok_valid || (take && last);
	assign tok       = toks_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			n_q   <= set.count;
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			toks_q <= set.tok;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("token set loaded over undelivered words");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && set.count != 2'd0 |=> tok_valid && idx_q == 2'd0)
		else $error("loaded token set not presented");

endmodule

// ----- rtl/assembler_token_scanner_unit.sv -----
// Channel | Direction | Handshake            | Word
// --------+-----------+----------------------+--------------------------------------------
// source  | in        | src_valid / src_stall| in_char, at_end
// token   | out       | tok_valid / tok_stall| token_kind, token_char, token_value,
//         |           |                      | error_code, last
//
// A source word is held in the input register, is scanned in one pass and lands in the
// token register as a set of zero to three tokens. The token port moves one word per
// cycle while tok_stall is low, so a source word that yields k tokens holds the source
// side until all k are taken; words yielding one token or none flow at one per cycle.
// Reset (arst_n low) clears scanner mode, accumulator, base, identifier length and both
// valid flags; it is the only way out of the halted mode after an overlong identifier.
// src_stall rises only while a scanned word waits for the token register to drain.
module assembler_token_scanner_unit #(
	parameter int VALUE_BITS  = ats_pkg::VALUE_BITS_DEF,
	parameter int IDENT_LIMIT = ats_pkg::IDENT_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  in_char,
	input  logic        at_end,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [2:0]  token_kind,
	output logic [7:0]  token_char,
	output logic [31:0] token_value,
	output logic [2:0]  error_code,
	output logic        last
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              end_s1;
	logic              buf_free;
	logic              adv;
	ats_pkg::tok_set_t set;
	ats_pkg::tok_t     tok;

	// advance the held word once the token register can take its whole set
	assign adv       = valid_s1 && buf_free;
	assign src_stall = valid_s1 && !buf_free;

	// input register: refill whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			char_s1 <= in_char;
			end_s1  <= at_end;
		end
	end

	// mode register, accumulator and the one-pass token logic
	ats_scan #(
		.VALUE_BITS  (VALUE_BITS),
		.IDENT_LIMIT (IDENT_LIMIT)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ch     (char_s1),
		.is_end (end_s1),
		.set    (set)
	);

	// token register: hold the set, drain one word per handshake
	ats_result_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.set       (set),
		.free      (buf_free),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.last      (last)
	);

	assign token_kind  = tok.kind;
	assign token_char  = tok.ch;
	assign token_value = tok.value;
	assign error_code  = tok.code;

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && tok_valid)
		else $error("source stalled with nothing pending");

endmodule
